>>> hdl/bresenham_line_rasterizer_top_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer assertion macros
// Shared concurrent assertion forms for the line rasterizer checkers.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BLR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BLR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, field offsets, codes and shared types of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS         = 16;
  localparam int DELTA_BITS         = COORD_BITS + 1;
  localparam int ERR_BITS           = COORD_BITS + 3;
  localparam int CFG_DIM_BITS       = 13;
  localparam int COLOR_BITS         = 32;
  localparam int INDEX_BITS         = 24;
  localparam int CFG_ADDR_BITS      = 2;
  localparam int CFG_DATA_BITS      = 32;
  localparam int DEF_MAX_TARGET_DIM = 4096;

  localparam logic [CFG_DIM_BITS-1:0] RST_TARGET_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_BITS-1:0] RST_TARGET_HEIGHT = 13'd480;
  localparam logic [COLOR_BITS-1:0]   RST_DRAW_COLOR    = 32'hFF00_0000;

  // Input word layout: start_x, start_y, end_x, end_y from the lowest bit up
  localparam int IN_X1_LSB    = 0;
  localparam int IN_Y1_LSB    = IN_X1_LSB + COORD_BITS;
  localparam int IN_X2_LSB    = IN_Y1_LSB + COORD_BITS;
  localparam int IN_Y2_LSB    = IN_X2_LSB + COORD_BITS;
  localparam int IN_DATA_BITS = IN_Y2_LSB + COORD_BITS;

  // Output word layout: pixel_x, pixel_y, pixel_index, color
  localparam int OUT_X_LSB     = 0;
  localparam int OUT_Y_LSB     = OUT_X_LSB + COORD_BITS;
  localparam int OUT_IDX_LSB   = OUT_Y_LSB + COORD_BITS;
  localparam int OUT_COLOR_LSB = OUT_IDX_LSB + INDEX_BITS;
  localparam int OUT_DATA_BITS = OUT_COLOR_LSB + COLOR_BITS;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_TARGET_WIDTH  = 2'd0,
    CFG_TARGET_HEIGHT = 2'd1,
    CFG_DRAW_COLOR    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } point_t;

endpackage

`default_nettype wire

>>> hdl/blr_stepper.sv
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Holds the Bresenham state, takes start and tick words, and registers one
// line point per active tick.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_stepper (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             in_req_i,
  input  wire logic [blr_pkg::IN_DATA_BITS-1:0] in_data_i,
  output logic                                  pt_valid_o,
  input  wire logic                             pt_ready_i,
  output blr_pkg::point_t                       pt_o
);
  import blr_pkg::*;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] goal_x_q, goal_y_q;
  logic [DELTA_BITS-1:0]        dx_q, dy_q;
  logic                         sx_neg_q, sy_neg_q;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic                         active_q;
  logic                         pt_valid_q;
  point_t                       pt_q;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [DELTA_BITS-1:0] diff_x, diff_y;
  logic [DELTA_BITS-1:0]        dx_start, dy_start;
  logic signed [ERR_BITS:0]     e2;
  logic                         step_x, step_y, at_end;
  logic                         accept, start_fire, tick_fire;

  assign x1 = in_data_i[IN_X1_LSB +: COORD_BITS];
  assign y1 = in_data_i[IN_Y1_LSB +: COORD_BITS];
  assign x2 = in_data_i[IN_X2_LSB +: COORD_BITS];
  assign y2 = in_data_i[IN_Y2_LSB +: COORD_BITS];

  assign diff_x   = DELTA_BITS'(x2) - DELTA_BITS'(x1);
  assign diff_y   = DELTA_BITS'(y2) - DELTA_BITS'(y1);
  assign dx_start = diff_x[DELTA_BITS-1] ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
  assign dy_start = diff_y[DELTA_BITS-1] ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);

  assign in_ready_o = !pt_valid_q || pt_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign start_fire = accept && (in_req_i == REQ_START);
  assign tick_fire  = accept && (in_req_i == REQ_TICK) && active_q;

  // Error rule: e2 = 2*err, step x when e2 > -dy, step y when e2 < dx
  assign e2     = {err_q, 1'b0};
  assign step_x = e2 > -$signed({2'b00, dy_q});
  assign step_y = e2 < $signed({2'b00, dx_q});
  assign at_end = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

  always_comb begin
    err_d   = err_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    if (step_x) begin
      err_d   = err_d - $signed({2'b00, dy_q});
      cur_x_d = sx_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
    end
    if (step_y) begin
      err_d   = err_d + $signed({2'b00, dx_q});
      cur_y_d = sy_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      sx_neg_q <= 1'b0;
      sy_neg_q <= 1'b0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else if (start_fire) begin
      cur_x_q  <= x1;
      cur_y_q  <= y1;
      goal_x_q <= x2;
      goal_y_q <= y2;
      dx_q     <= dx_start;
      dy_q     <= dy_start;
      sx_neg_q <= !(x1 < x2);
      sy_neg_q <= !(y1 < y2);
      err_q    <= $signed({2'b00, dx_start}) - $signed({2'b00, dy_start});
      active_q <= 1'b1;
    end else if (tick_fire) begin
      if (at_end) begin
        active_q <= 1'b0;
      end else begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q <= 1'b0;
    end else if (tick_fire) begin
      pt_valid_q <= 1'b1;
    end else if (pt_ready_i) begin
      pt_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      pt_q.x    <= cur_x_q;
      pt_q.y    <= cur_y_q;
      pt_q.last <= at_end;
    end
  end

  assign pt_valid_o = pt_valid_q;
  assign pt_o       = pt_q;

endmodule

`default_nettype wire

>>> hdl/bresenham_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Integer line generator with clipping to the draw target and pixel indexing.
// ----------------------------------------------------------------------------
// A start word (tuser = 0) loads two signed endpoints and gives no output; a
// tick word (tuser = 1) gives one output word for the current point while a
// line is active, and nothing when idle. The end point's word carries tlast,
// after which the generator is idle until the next start. One word is taken
// every clock while the output does not stall: the stepper's error update
// is combinational and registers the point, and the clip and index multiply
// sit between the point register and the output register. Output words that
// are not taken stall the input through the point and output registers.
// Program the target size and color only while no line point is in flight.
`default_nettype none

module bresenham_line_rasterizer_top #(
  parameter int MAX_TARGET_DIM = blr_pkg::DEF_MAX_TARGET_DIM
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [blr_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire logic [blr_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [blr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // req_type
  input  wire logic                              s_axis_tuser,
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pixel_x, pixel_y, pixel_index, color
  output logic [blr_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
  // visible
  output logic                                   m_axis_tuser,
  // last
  output logic                                   m_axis_tlast
);
  import blr_pkg::*;

  localparam int DIM_BITS  = $clog2(MAX_TARGET_DIM + 1);
  localparam int CMP_BITS0 = (DIM_BITS > CFG_DIM_BITS) ? DIM_BITS : CFG_DIM_BITS;
  localparam int CMP_BITS  = (CMP_BITS0 > COORD_BITS) ? CMP_BITS0 : COORD_BITS;
  localparam int MUL_BITS  = COORD_BITS - 1 + CMP_BITS;

  logic [CFG_DIM_BITS-1:0] width_q, height_q;
  logic [COLOR_BITS-1:0]   color_q;

  logic                    pt_valid, pt_ready;
  point_t                  pt;

  logic [CMP_BITS-1:0]     w_ext, h_ext, w_clamp, h_clamp, x_ext, y_ext;
  logic [MUL_BITS-1:0]     row_base;
  logic [MUL_BITS:0]       lin_index;
  logic                    vis;
  logic [INDEX_BITS-1:0]   pix_index;

  logic                    m_valid_q;
  logic [OUT_DATA_BITS-1:0] m_data_q;
  logic                    m_user_q, m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_TARGET_WIDTH;
      height_q <= RST_TARGET_HEIGHT;
      color_q  <= RST_DRAW_COLOR;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TARGET_WIDTH:  width_q  <= cfg_wdata_i[CFG_DIM_BITS-1:0];
        CFG_TARGET_HEIGHT: height_q <= cfg_wdata_i[CFG_DIM_BITS-1:0];
        CFG_DRAW_COLOR:    color_q  <= cfg_wdata_i[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  blr_stepper u_stepper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .pt_valid_o (pt_valid),
    .pt_ready_i (pt_ready),
    .pt_o       (pt)
  );

  // Clip against the saturated target size and build the linear index
  assign w_ext   = CMP_BITS'(width_q);
  assign h_ext   = CMP_BITS'(height_q);
  assign w_clamp = (w_ext > CMP_BITS'(MAX_TARGET_DIM)) ? CMP_BITS'(MAX_TARGET_DIM) : w_ext;
  assign h_clamp = (h_ext > CMP_BITS'(MAX_TARGET_DIM)) ? CMP_BITS'(MAX_TARGET_DIM) : h_ext;
  assign x_ext   = CMP_BITS'(pt.x[COORD_BITS-2:0]);
  assign y_ext   = CMP_BITS'(pt.y[COORD_BITS-2:0]);

  assign vis = !pt.x[COORD_BITS-1] && !pt.y[COORD_BITS-1] &&
               (x_ext < w_clamp) && (y_ext < h_clamp);

  assign row_base  = MUL_BITS'(pt.y[COORD_BITS-2:0]) * MUL_BITS'(w_clamp);
  assign lin_index = {1'b0, row_base} + (MUL_BITS + 1)'(x_ext);
  assign pix_index = vis ? INDEX_BITS'(lin_index) : '0;

  assign pt_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pt_ready) begin
      m_valid_q <= pt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_valid && pt_ready) begin
      m_data_q <= {color_q, pix_index, pt.y, pt.x};
      m_user_q <= vis;
      m_last_q <= pt.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

>>> hdl/blr_checker.sv
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Watches the rasterizer's ports and flags output words that break its rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_top_defines.svh"

module blr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [blr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import blr_pkg::*;

  // Hold a stalled output word
  `BLR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

  // Clipped points carry a zero index
  `BLR_ASSERT(a_hidden_index, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_IDX_LSB +: INDEX_BITS] == '0, "invisible point has nonzero index")

  // Visible points lie in the nonnegative quadrant
  `BLR_ASSERT(a_visible_coords, m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[OUT_X_LSB + COORD_BITS - 1] && !m_axis_tdata[OUT_Y_LSB + COORD_BITS - 1], "visible point has negative coordinate")

  // No output word leaves the block right after reset
  `BLR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (.*);

`default_nettype wire

>>> dv/tb_bresenham_line_rasterizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives start and tick words into the rasterizer, predicts every emitted
// line point (coordinates, clip flag, linear index, color, end marker) and
// checks each output word against the oldest prediction, under random
// stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_bresenham_line_rasterizer_top;
  import blr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int MAX_GAP       = 12;
  localparam int LIMIT_NS      = 4_000_000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [INDEX_BITS-1:0]        index;
    logic                         visible;
    logic [COLOR_BITS-1:0]        color;
    logic                         last;
  } pixel_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;

  // Predicted target registers
  logic [CFG_DIM_BITS-1:0] tgt_width  = RST_TARGET_WIDTH;
  logic [CFG_DIM_BITS-1:0] tgt_height = RST_TARGET_HEIGHT;
  logic [COLOR_BITS-1:0]   line_color = RST_DRAW_COLOR;

  // Predicted stepper state
  logic signed [COORD_BITS-1:0] pt_x = '0, pt_y = '0;
  logic signed [COORD_BITS-1:0] end_x_q = '0, end_y_q = '0;
  logic [DELTA_BITS-1:0]        run_dx = '0, run_dy = '0;
  logic                         x_back = 1'b0, y_back = 1'b0;
  logic signed [ERR_BITS-1:0]   step_err = '0;
  logic                         line_active = 1'b0;

  pixel_t expected_pixels[$];
  int     failures      = 0;
  int     words_sent    = 0;
  int     src_idle_pct  = 0;
  int     sink_idle_pct = 0;
  int     hold_asked    = 0;
  int     hold_seen     = 0;
  int     hold_left     = 0;

  bresenham_line_rasterizer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // start_x, start_y, end_x, end_y
    .s_axis_tuser (s_axis_tuser),   // req_type
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // pixel_x, pixel_y, pixel_index, color
    .m_axis_tuser (m_axis_tuser),   // visible
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Output ready: a requested hold-off wins over the random stall pattern
  always @(posedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen     <= hold_asked;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic void log_mismatch(string what, pixel_t want, pixel_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: exp x=%0d y=%0d idx=%0d vis=%0b color=%h last=%0b",
               $time, what, want.x, want.y, want.index, want.visible, want.color,
               want.last);
      $display("%0t: %s: got x=%0d y=%0d idx=%0d vis=%0b color=%h last=%0b",
               $time, what, got.x, got.y, got.index, got.visible, got.color,
               got.last);
    end
  endfunction

  always @(posedge clk_i) begin : check_pixels
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x       = m_axis_tdata[OUT_X_LSB +: COORD_BITS];
      got.y       = m_axis_tdata[OUT_Y_LSB +: COORD_BITS];
      got.index   = m_axis_tdata[OUT_IDX_LSB +: INDEX_BITS];
      got.color   = m_axis_tdata[OUT_COLOR_LSB +: COLOR_BITS];
      got.visible = m_axis_tuser;
      got.last    = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        log_mismatch("pixel word with none expected", '0, got);
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
            got.visible !== want.visible || got.color !== want.color ||
            got.last !== want.last) begin
          log_mismatch("pixel word mismatch", want, got);
        end
      end
    end
  end

  // Load a line on a start word; on a tick emit the current point and step it
  function automatic void advance_line(input req_e kind,
                                       input logic [IN_DATA_BITS-1:0] word);
    int     x1, y1, x2, y2, w, h, px, py, e2, dxi, dyi;
    pixel_t pix;
    if (kind == REQ_START) begin
      x1 = int'($signed(word[IN_X1_LSB +: COORD_BITS]));
      y1 = int'($signed(word[IN_Y1_LSB +: COORD_BITS]));
      x2 = int'($signed(word[IN_X2_LSB +: COORD_BITS]));
      y2 = int'($signed(word[IN_Y2_LSB +: COORD_BITS]));
      pt_x        = x1[COORD_BITS-1:0];
      pt_y        = y1[COORD_BITS-1:0];
      end_x_q     = x2[COORD_BITS-1:0];
      end_y_q     = y2[COORD_BITS-1:0];
      dxi         = (x2 > x1) ? x2 - x1 : x1 - x2;
      dyi         = (y2 > y1) ? y2 - y1 : y1 - y2;
      run_dx      = dxi[DELTA_BITS-1:0];
      run_dy      = dyi[DELTA_BITS-1:0];
      x_back      = !(x1 < x2);
      y_back      = !(y1 < y2);
      step_err    = ERR_BITS'(dxi - dyi);
      line_active = 1'b1;
      return;
    end
    if (!line_active) return;

    // Oversize targets saturate to the largest supported surface
    w  = (tgt_width > DEF_MAX_TARGET_DIM) ? DEF_MAX_TARGET_DIM : int'(tgt_width);
    h  = (tgt_height > DEF_MAX_TARGET_DIM) ? DEF_MAX_TARGET_DIM : int'(tgt_height);
    px = int'(pt_x);
    py = int'(pt_y);
    pix.x       = pt_x;
    pix.y       = pt_y;
    pix.visible = (px >= 0) && (py >= 0) && (px < w) && (py < h);
    pix.index   = pix.visible ? INDEX_BITS'(py * w + px) : '0;
    pix.color   = line_color;
    pix.last    = (pt_x == end_x_q) && (pt_y == end_y_q);
    expected_pixels.push_back(pix);

    if (pix.last) begin
      line_active = 1'b0;
    end else begin
      e2  = 2 * int'(step_err);
      dxi = int'(run_dx);
      dyi = int'(run_dy);
      if (e2 > -dyi) begin
        step_err = ERR_BITS'(int'(step_err) - dyi);
        pt_x     = x_back ? pt_x - COORD_BITS'(1) : pt_x + COORD_BITS'(1);
      end
      if (e2 < dxi) begin
        step_err = ERR_BITS'(int'(step_err) + dxi);
        pt_y     = y_back ? pt_y - COORD_BITS'(1) : pt_y + COORD_BITS'(1);
      end
    end
  endfunction

  task automatic send_word(input req_e kind, input logic [IN_DATA_BITS-1:0] word);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    // ticks on an idle generator are ignored and not counted
    if (kind == REQ_START || line_active) words_sent++;
    advance_line(kind, word);
  endtask

  task automatic send_start(input int x1, input int y1, input int x2, input int y2);
    send_word(REQ_START, {y2[COORD_BITS-1:0], x2[COORD_BITS-1:0],
                          y1[COORD_BITS-1:0], x1[COORD_BITS-1:0]});
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(REQ_TICK, {$urandom, $urandom});
  endtask

  // Drop valid, then wait out every expected word and the pipeline tail
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGET_WIDTH:  tgt_width  = val[CFG_DIM_BITS-1:0];
      CFG_TARGET_HEIGHT: tgt_height = val[CFG_DIM_BITS-1:0];
      CFG_DRAW_COLOR:    line_color = val[COLOR_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_target(input logic [CFG_DATA_BITS-1:0] w,
                            input logic [CFG_DATA_BITS-1:0] h,
                            input logic [CFG_DATA_BITS-1:0] color);
    wait_drained();
    write_reg(CFG_TARGET_WIDTH, w);
    write_reg(CFG_TARGET_HEIGHT, h);
    write_reg(CFG_DRAW_COLOR, color);
  endtask

  task automatic test_idle_tick_and_point();
    send_ticks(1);
    send_start(5, 5, 5, 5);
    send_ticks(2);
    // crosses the right edge of the reset-size target
    send_start(638, 479, 641, 480);
    send_ticks(4);
  endtask

  task automatic test_coordinate_extremes();
    send_start(-32768, 32767, 32767, -32768);
    send_ticks(2);
    // restart mid-line at the opposite corner
    send_start(32767, -32768, 32766, -32767);
    send_ticks(2);
  endtask

  task automatic test_target_edges();
    // saturate the target and reach the largest pixel index
    set_target(32'd8191, 32'hFFFF_FFFF, 32'h1234_5678);
    send_start(4094, 4095, 4096, 4095);
    send_ticks(3);
    set_target(32'd0, 32'd0, 32'h0000_0000);
    send_start(0, 0, 1, 0);
    send_ticks(2);
  endtask

  task automatic test_retarget_mid_line();
    set_target(32'd640, 32'd480, 32'hFFFF_FFFF);
    send_start(0, 1, 3, 1);
    send_ticks(2);
    // shrink the target while the line is still open
    wait_drained();
    write_reg(CFG_TARGET_WIDTH, 32'd2);
    send_ticks(2);
  endtask

  task automatic test_random_lines(input int src_pct, input int sink_pct,
                                   input int n_words, input int reach);
    int goal, w, h, x1, y1, x2, y2, dx, dy, span, n, reach_now;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      w = (tgt_width > DEF_MAX_TARGET_DIM) ? DEF_MAX_TARGET_DIM : int'(tgt_width);
      h = (tgt_height > DEF_MAX_TARGET_DIM) ? DEF_MAX_TARGET_DIM : int'(tgt_height);
      if ($urandom_range(19) == 0) begin
        // noise: any endpoints, a few ticks, then abandon the line
        send_start($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                   $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        send_ticks($urandom_range(3));
      end else begin
        x1 = ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                      : $urandom_range(w + 3) - 2;
        y1 = ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                      : $urandom_range(h + 3) - 2;
        reach_now = ($urandom_range(7) == 0) ? 4 * reach : reach;
        dx = $urandom_range(reach_now);
        dy = $urandom_range(reach_now);
        if ($urandom_range(1) == 1) dx = -dx;
        if ($urandom_range(1) == 1) dy = -dy;
        x2 = x1 + dx;
        y2 = y1 + dy;
        if (x2 > 32767 || x2 < -32768) x2 = x1 - dx;
        if (y2 > 32767 || y2 < -32768) y2 = y1 - dy;
        span = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                            : (dy < 0 ? -dy : dy);
        span = span + 1;
        send_start(x1, y1, x2, y2);
        if ($urandom_range(9) == 0) n = $urandom_range(span - 1);
        else n = span + $urandom_range(2);
        send_ticks(n);
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_start(0, 0, 99, 37);
    // hold the output while ticks keep coming, so the input stalls
    hold_asked++;
    send_ticks(100);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct  = 33;
    sink_idle_pct = 67;

    test_idle_tick_and_point();
    test_coordinate_extremes();
    test_target_edges();
    test_retarget_mid_line();

    set_target(32'd64, 32'd48, $urandom);
    test_random_lines(33, 67, 130, 12);
    set_target(32'd4096, 32'd1, 32'h0000_0000);
    test_random_lines(67, 33, 130, 12);
    set_target(32'd1, 32'd4096, 32'hFFFF_FFFF);
    test_random_lines(0, 0, 70, 12);
    set_target({3'($urandom_range(7)), 16'h0, 1'b0, 12'($urandom_range(4095))},
               $urandom_range(1, 4096), $urandom);
    test_random_lines(0, 0, 70, 12);
    test_backpressure();

    wait_drained();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
